### rtl/mi4_pkg.sv
`timescale 1ns / 1ps

package mi4_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FIRST,
        ST_MSET,
        ST_MUL,
        ST_ACC,
        ST_DSET,
        ST_DMUL,
        ST_DACC,
        ST_CHECK,
        ST_DPREP,
        ST_DIV,
        ST_RES,
        ST_SING
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_X_FIRST,
        OP_MSET,
        OP_MSTEP,
        OP_MLAST,
        OP_ACC,
        OP_DSET,
        OP_DACC,
        OP_CHECK,
        OP_DPREP,
        OP_DSTEP,
        OP_RES,
        OP_SING
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] k;
        logic [2:0] p;
        logic [1:0] j;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } dp_status_t;

    // Column order of factor j in the six terms of a 3x3 expansion;
    // terms 0..2 are even permutations, 3..5 odd.
    function automatic logic [1:0] perm3(input logic [2:0] p, input logic [1:0] j);
        logic [5:0] row;
        case (p)
            3'd0: row = {2'd2, 2'd1, 2'd0};
            3'd1: row = {2'd0, 2'd2, 2'd1};
            3'd2: row = {2'd1, 2'd0, 2'd2};
            3'd3: row = {2'd1, 2'd2, 2'd0};
            3'd4: row = {2'd2, 2'd0, 2'd1};
            3'd5: row = {2'd0, 2'd1, 2'd2};
            default: row = 6'd0;
        endcase
        case (j)
            2'd0: return row[1:0];
            2'd1: return row[3:2];
            default: return row[5:4];
        endcase
    endfunction

    // Flat address of factor j of term p of the cofactor for adjugate entry k.
    function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [2:0] p,
                                             input logic [1:0] j);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] m;
        logic [1:0] row;
        logic [1:0] col;
        r   = k[3:2];
        c   = k[1:0];
        m   = perm3(p, j);
        row = (j < c) ? j : j + 2'd1;
        col = (m < r) ? m : m + 2'd1;
        return {row, col};
    endfunction

endpackage

### rtl/mi4_ctrl.sv
`timescale 1ns / 1ps

module mi4_ctrl #(
    parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mi4_pkg::dp_status_t status,
    output mi4_pkg::dp_cmd_t    cmd
);

    localparam int SW = $clog2(ELEM_WIDTH + 1);
    localparam logic [SW-1:0] MUL_LAST_STEP = SW'(ELEM_WIDTH - 1);
    localparam logic [SW-1:0] DIV_LAST_STEP = SW'(ELEM_WIDTH);

    mi4_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [2:0]    p_reg, p_next;
    logic [1:0]    j_reg, j_next;
    logic [SW-1:0] step_reg, step_next;

    // next state and counters
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        step_next  = step_reg;
        case (state_reg)
            mi4_pkg::ST_LOAD: begin
                if (s_valid) begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        p_next     = 3'd0;
                        state_next = mi4_pkg::ST_FIRST;
                    end
                end
            end
            mi4_pkg::ST_FIRST: begin
                j_next     = 2'd1;
                state_next = mi4_pkg::ST_MSET;
            end
            mi4_pkg::ST_MSET: begin
                step_next  = '0;
                state_next = mi4_pkg::ST_MUL;
            end
            mi4_pkg::ST_MUL: begin
                if (step_reg == MUL_LAST_STEP) begin
                    if (j_reg == 2'd1) begin
                        j_next     = 2'd2;
                        state_next = mi4_pkg::ST_MSET;
                    end else begin
                        state_next = mi4_pkg::ST_ACC;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            mi4_pkg::ST_ACC: begin
                if (p_reg == 3'd5) begin
                    p_next   = 3'd0;
                    cnt_next = cnt_reg + 4'd1;
                    state_next = (cnt_reg == 4'd15) ? mi4_pkg::ST_DSET : mi4_pkg::ST_FIRST;
                end else begin
                    p_next     = p_reg + 3'd1;
                    state_next = mi4_pkg::ST_FIRST;
                end
            end
            mi4_pkg::ST_DSET: begin
                step_next  = '0;
                state_next = mi4_pkg::ST_DMUL;
            end
            mi4_pkg::ST_DMUL: begin
                if (step_reg == MUL_LAST_STEP) begin
                    state_next = mi4_pkg::ST_DACC;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            mi4_pkg::ST_DACC: begin
                if (cnt_reg == 4'd3) begin
                    cnt_next   = 4'd0;
                    state_next = mi4_pkg::ST_CHECK;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = mi4_pkg::ST_DSET;
                end
            end
            mi4_pkg::ST_CHECK: begin
                state_next = status.det_zero ? mi4_pkg::ST_SING : mi4_pkg::ST_DPREP;
            end
            mi4_pkg::ST_DPREP: begin
                step_next  = '0;
                state_next = mi4_pkg::ST_DIV;
            end
            mi4_pkg::ST_DIV: begin
                if (step_reg == DIV_LAST_STEP) begin
                    state_next = mi4_pkg::ST_RES;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            mi4_pkg::ST_RES: begin
                if (status.out_free) begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = (cnt_reg == 4'd15) ? mi4_pkg::ST_LOAD : mi4_pkg::ST_DPREP;
                end
            end
            mi4_pkg::ST_SING: begin
                if (status.out_free) begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_next = mi4_pkg::ST_LOAD;
                    end
                end
            end
            default: state_next = mi4_pkg::ST_LOAD;
        endcase
    end

    // command outputs
    always_comb begin
        cmd.op = mi4_pkg::OP_NONE;
        cmd.k  = cnt_reg;
        cmd.p  = p_reg;
        cmd.j  = j_reg;
        s_ready = 1'b0;
        case (state_reg)
            mi4_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = mi4_pkg::OP_LOAD;
                end
            end
            mi4_pkg::ST_FIRST: begin
                cmd.op = mi4_pkg::OP_X_FIRST;
                cmd.j  = 2'd0;
            end
            mi4_pkg::ST_MSET:  cmd.op = mi4_pkg::OP_MSET;
            mi4_pkg::ST_MUL, mi4_pkg::ST_DMUL: begin
                cmd.op = (step_reg == MUL_LAST_STEP) ? mi4_pkg::OP_MLAST : mi4_pkg::OP_MSTEP;
            end
            mi4_pkg::ST_ACC:   cmd.op = mi4_pkg::OP_ACC;
            mi4_pkg::ST_DSET:  cmd.op = mi4_pkg::OP_DSET;
            mi4_pkg::ST_DACC:  cmd.op = mi4_pkg::OP_DACC;
            mi4_pkg::ST_CHECK: cmd.op = mi4_pkg::OP_CHECK;
            mi4_pkg::ST_DPREP: cmd.op = mi4_pkg::OP_DPREP;
            mi4_pkg::ST_DIV:   cmd.op = mi4_pkg::OP_DSTEP;
            mi4_pkg::ST_RES: begin
                if (status.out_free) begin
                    cmd.op = mi4_pkg::OP_RES;
                end
            end
            mi4_pkg::ST_SING: begin
                if (status.out_free) begin
                    cmd.op = mi4_pkg::OP_SING;
                end
            end
            default: cmd.op = mi4_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mi4_pkg::ST_LOAD;
            cnt_reg   <= 4'd0;
            p_reg     <= 3'd0;
            j_reg     <= 2'd0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            p_reg     <= p_next;
            j_reg     <= j_next;
            step_reg  <= step_next;
        end
    end

    a_res_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == mi4_pkg::OP_RES || cmd.op == mi4_pkg::OP_SING) |-> status.out_free)
        else $error("result written while output slot busy");

    a_full_load_starts_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mi4_pkg::ST_LOAD && s_valid && cnt_reg == 4'd15)
        |=> state_reg == mi4_pkg::ST_FIRST)
        else $error("sixteenth item did not start the computation");

endmodule

### rtl/mi4_datapath.sv
`timescale 1ns / 1ps

module mi4_datapath #(
    parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mi4_pkg::dp_cmd_t             cmd,
    output mi4_pkg::dp_status_t          status,
    input  logic signed [ELEM_WIDTH-1:0] s_element_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [ELEM_WIDTH-1:0] m_result_value,
    output logic [3:0]                   m_result_index,
    output logic                         m_singular,
    output logic                         m_saturated,
    output logic                         m_last
);

    localparam int E  = ELEM_WIDTH;
    localparam int AW = 4 * E + 4;         // holds determinant and adjugate exactly
    localparam int NW = AW + 2 * FRAC_BITS; // scaled dividend and remainder
    localparam logic [E:0]   MAXPOS = {2'b00, {(E - 1){1'b1}}};
    localparam logic [E:0]   MINMAG = {2'b01, {(E - 1){1'b0}}};
    localparam logic [E-1:0] ONE_FX = {{(E - 1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [E-1:0]  elem_reg [16];
    logic [E-1:0]  elem_next [16];
    logic [AW-1:0] adj_reg [16];
    logic [AW-1:0] adj_next [16];

    logic [AW-1:0] x_reg, x_next;
    logic [AW-1:0] xs_reg, xs_next;
    logic [AW-1:0] pr_reg, pr_next;
    logic [E-1:0]  me_reg, me_next;
    logic [AW-1:0] sum_reg, sum_next;
    logic [AW-1:0] det_reg, det_next;
    logic [AW-1:0] dmag_reg, dmag_next;
    logic          dneg_reg, dneg_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [E:0]    nsh_reg, nsh_next;
    logic [E:0]    q_reg, q_next;
    logic          sat0_reg, sat0_next;
    logic          qneg_reg, qneg_next;

    logic          m_valid_reg, m_valid_next;
    logic [E-1:0]  val_reg, val_next;
    logic [3:0]    idx_reg, idx_next;
    logic          sing_reg, sing_next;
    logic          sat_reg, sat_next;
    logic          last_reg, last_next;

    logic [3:0]    rd_addr;
    logic [3:0]    adj_addr;
    logic [E-1:0]  rd_elem;
    logic [AW-1:0] rd_elem_ext;
    logic [AW-1:0] rd_adj;
    logic [AW-1:0] addend;
    logic          term_neg;
    logic [AW-1:0] amag;
    logic [NW-1:0] nfull;
    logic [NW-1:0] remsh;
    logic [NW-1:0] dmag_ext;
    logic          out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign status.out_free = out_free;
    assign status.det_zero = (det_reg == '0);

    assign rd_addr     = (cmd.op == mi4_pkg::OP_DSET) ? cmd.k
                         : mi4_pkg::elem_addr(cmd.k, cmd.p, cmd.j);
    assign rd_elem     = elem_reg[rd_addr];
    assign rd_elem_ext = {{(AW - E){rd_elem[E-1]}}, rd_elem};
    assign adj_addr    = (cmd.op == mi4_pkg::OP_DSET) ? {cmd.k[1:0], 2'b00} : cmd.k;
    assign rd_adj      = adj_reg[adj_addr];

    assign addend   = me_reg[0] ? xs_reg : '0;
    // odd permutation and odd cofactor position each flip the sign
    assign term_neg = (cmd.p >= 3'd3) ^ cmd.k[2] ^ cmd.k[0];
    assign amag     = rd_adj[AW-1] ? (~rd_adj + 1'b1) : rd_adj;
    assign nfull    = {amag, {(2 * FRAC_BITS){1'b0}}};
    assign remsh    = {rem_reg[NW-2:0], nsh_reg[E]};
    assign dmag_ext = {{(NW - AW){1'b0}}, dmag_reg};

    always_comb begin
        elem_next    = elem_reg;
        adj_next     = adj_reg;
        x_next       = x_reg;
        xs_next      = xs_reg;
        pr_next      = pr_reg;
        me_next      = me_reg;
        sum_next     = sum_reg;
        det_next     = det_reg;
        dmag_next    = dmag_reg;
        dneg_next    = dneg_reg;
        rem_next     = rem_reg;
        nsh_next     = nsh_reg;
        q_next       = q_reg;
        sat0_next    = sat0_reg;
        qneg_next    = qneg_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        sing_next    = sing_reg;
        sat_next     = sat_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (cmd.op)
            mi4_pkg::OP_LOAD: begin
                elem_next[cmd.k] = s_element_value;
                sum_next         = '0;
            end
            mi4_pkg::OP_X_FIRST: x_next = rd_elem_ext;
            mi4_pkg::OP_MSET: begin
                xs_next = x_reg;
                me_next = rd_elem;
                pr_next = '0;
            end
            mi4_pkg::OP_MSTEP: begin
                pr_next = pr_reg + addend;
                xs_next = xs_reg << 1;
                me_next = me_reg >> 1;
            end
            mi4_pkg::OP_MLAST: begin
                // sign bit of the element carries negative weight
                x_next = pr_reg - addend;
            end
            mi4_pkg::OP_ACC: begin
                sum_next = term_neg ? (sum_reg - x_reg) : (sum_reg + x_reg);
                if (cmd.p == 3'd5) begin
                    adj_next[cmd.k] = sum_next;
                    sum_next        = '0;
                end
            end
            mi4_pkg::OP_DSET: begin
                xs_next = rd_adj;
                me_next = rd_elem;
                pr_next = '0;
                if (cmd.k == 4'd0) begin
                    det_next = '0;
                end
            end
            mi4_pkg::OP_DACC: det_next = det_reg + x_reg;
            mi4_pkg::OP_CHECK: begin
                dneg_next = det_reg[AW-1];
                dmag_next = det_reg[AW-1] ? (~det_reg + 1'b1) : det_reg;
            end
            mi4_pkg::OP_DPREP: begin
                rem_next  = nfull >> (E + 1);
                sat0_next = (nfull >> (E + 1)) >= dmag_ext;
                nsh_next  = nfull[E:0];
                q_next    = '0;
                qneg_next = rd_adj[AW-1] ^ dneg_reg;
            end
            mi4_pkg::OP_DSTEP: begin
                nsh_next = nsh_reg << 1;
                if (remsh >= dmag_ext) begin
                    rem_next = remsh - dmag_ext;
                    q_next   = {q_reg[E-1:0], 1'b1};
                end else begin
                    rem_next = remsh;
                    q_next   = {q_reg[E-1:0], 1'b0};
                end
            end
            mi4_pkg::OP_RES: begin
                m_valid_next = 1'b1;
                idx_next     = cmd.k;
                sing_next    = 1'b0;
                last_next    = (cmd.k == 4'd15);
                if (qneg_reg) begin
                    if (sat0_reg || q_reg > MINMAG) begin
                        val_next = MINMAG[E-1:0];
                        sat_next = 1'b1;
                    end else begin
                        val_next = (~q_reg[E-1:0]) + 1'b1;
                        sat_next = 1'b0;
                    end
                end else begin
                    if (sat0_reg || q_reg > MAXPOS) begin
                        val_next = MAXPOS[E-1:0];
                        sat_next = 1'b1;
                    end else begin
                        val_next = q_reg[E-1:0];
                        sat_next = 1'b0;
                    end
                end
            end
            mi4_pkg::OP_SING: begin
                m_valid_next = 1'b1;
                idx_next     = cmd.k;
                sing_next    = 1'b1;
                sat_next     = 1'b0;
                last_next    = (cmd.k == 4'd15);
                // identity: diagonal where row equals column
                val_next     = (cmd.k[3:2] == cmd.k[1:0]) ? ONE_FX : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
        adj_reg  <= adj_next;
        x_reg    <= x_next;
        xs_reg   <= xs_next;
        pr_reg   <= pr_next;
        me_reg   <= me_next;
        sum_reg  <= sum_next;
        det_reg  <= det_next;
        dmag_reg <= dmag_next;
        dneg_reg <= dneg_next;
        rem_reg  <= rem_next;
        nsh_reg  <= nsh_next;
        q_reg    <= q_next;
        sat0_reg <= sat0_next;
        qneg_reg <= qneg_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        sing_reg <= sing_next;
        sat_reg  <= sat_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = val_reg;
    assign m_result_index = idx_reg;
    assign m_singular     = sing_reg;
    assign m_saturated    = sat_reg;
    assign m_last         = last_reg;

    a_singular_not_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_singular) |-> !m_saturated)
        else $error("singular result marked saturated");

    a_last_matches_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_result_index == 4'd15)))
        else $error("last flag disagrees with index");

endmodule

### rtl/matrix_inverse_4x4_core.sv
`timescale 1ns / 1ps

// 4x4 matrix inverse by cofactors, signed fixed point (Q16.16 by default).
// Input channel (s_): one matrix element per item, flat order 0..15 (row-major).
// The block takes one item per cycle while loading; after the sixteenth it
// drops s_ready and computes. Result channel (m_): sixteen items per matrix,
// result_index 0..15 in order, last on index 15, singular when the
// determinant is zero (identity returned), saturated when a quotient clipped.
// Work per matrix: the sixteen elements are loaded, then the adjugate is
// formed from 96 triple terms (one bit-serial shift-add multiplier, two
// products per triple term), then the determinant from four products, then
// a zero check of the determinant, and then a restoring divider works out
// each result in turn (when singular, the identity is written instead).
// A stalled receiver holds the single output register; computation waits on
// it before writing the next result. Loading of the next matrix starts once
// the last result sits in the output register.
// Reset (aresetn low, synchronous) returns to loading with an empty output.

module matrix_inverse_4x4_core #(
    parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [ELEM_WIDTH-1:0] s_element_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [ELEM_WIDTH-1:0] m_result_value,
    output logic [3:0]                   m_result_index,
    output logic                         m_singular,
    output logic                         m_saturated,
    output logic                         m_last
);

    mi4_pkg::dp_cmd_t    cmd;
    mi4_pkg::dp_status_t status;

    mi4_ctrl #(
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mi4_datapath #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_result_index  (m_result_index),
        .m_singular      (m_singular),
        .m_saturated     (m_saturated),
        .m_last          (m_last)
    );

endmodule
